### src/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### src/chacha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_pkg
// Types, constants and the microcode ROM of the ChaCha20 block function.
// ----------------------------------------------------------------------------
package chacha_pkg;

   localparam int unsigned DoubleRoundsDefault = 10;
   localparam int unsigned WordW   = 32;
   localparam int unsigned IdxW    = 4;
   localparam int unsigned KeyN    = 8;
   localparam int unsigned AddrW   = 5;
   localparam int unsigned PcW     = 4;

   localparam logic [WordW-1:0] SIGMA [4] = '{
      32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
   };

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_ROUND,
      OP_FINAL,
      OP_EMIT
   } op_type;

   // REQ: hold until a request is taken. LOOP: jump while rounds remain.
   // EMIT: hold until the last word is issued, then jump.
   typedef enum logic [2:0] {
      COND_NONE,
      COND_REQ,
      COND_LOOP,
      COND_EMIT,
      COND_JUMP
   } cond_type;

   typedef struct packed {
      op_type         op;
      logic           diag;
      logic [1:0]     phase;
      cond_type       cond;
      logic [PcW-1:0] target;
   } ucode_type;

   localparam logic [PcW-1:0] PC_LOAD  = 4'd0;
   localparam logic [PcW-1:0] PC_ROUND = 4'd1;
   localparam logic [PcW-1:0] PC_LAST  = 4'd10;

   function automatic ucode_type ucode_rom(input logic [PcW-1:0] pc);
      ucode_type u;
      u = '{op: OP_LOAD, diag: 1'b0, phase: 2'd0, cond: COND_JUMP, target: PC_LOAD};
      case (pc)
         4'd0:  u = '{OP_LOAD,  1'b0, 2'd0, COND_REQ,  PC_LOAD};
         4'd1:  u = '{OP_ROUND, 1'b0, 2'd0, COND_NONE, PC_LOAD};
         4'd2:  u = '{OP_ROUND, 1'b0, 2'd1, COND_NONE, PC_LOAD};
         4'd3:  u = '{OP_ROUND, 1'b0, 2'd2, COND_NONE, PC_LOAD};
         4'd4:  u = '{OP_ROUND, 1'b0, 2'd3, COND_NONE, PC_LOAD};
         4'd5:  u = '{OP_ROUND, 1'b1, 2'd0, COND_NONE, PC_LOAD};
         4'd6:  u = '{OP_ROUND, 1'b1, 2'd1, COND_NONE, PC_LOAD};
         4'd7:  u = '{OP_ROUND, 1'b1, 2'd2, COND_NONE, PC_LOAD};
         4'd8:  u = '{OP_ROUND, 1'b1, 2'd3, COND_LOOP, PC_ROUND};
         4'd9:  u = '{OP_FINAL, 1'b0, 2'd0, COND_NONE, PC_LOAD};
         4'd10: u = '{OP_EMIT,  1'b0, 2'd0, COND_EMIT, PC_LOAD};
         default: u = '{OP_LOAD, 1'b0, 2'd0, COND_JUMP, PC_LOAD};
      endcase
      return u;
   endfunction

   function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v,
                                             input logic [1:0] phase);
      logic [WordW-1:0] r;
      r = v;
      case (phase)
         2'd0:    r = {v[15:0], v[31:16]};
         2'd1:    r = {v[19:0], v[31:20]};
         2'd2:    r = {v[23:0], v[31:24]};
         default: r = {v[24:0], v[31:25]};
      endcase
      return r;
   endfunction

endpackage

### src/chacha20_block_function.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_block_function
// ChaCha20 keystream block generator, microcoded quarter-round datapath.
// ----------------------------------------------------------------------------
// Each request (block counter plus three nonce words) yields 16 keystream
// words, index 0 first, last_word set on index 15. A block is loaded, then
// runs DOUBLE_ROUNDS double rounds (one quarter-round step of four lanes
// per cycle), then the final add, and then its words are issued one by
// one. The next request is taken as soon as the last word sits in the
// output register. Key words are written over the APB port at byte
// address 4*i and must not change while a block is in work.
`include "assert_macros.svh"

module chacha20_block_function #(
   parameter int unsigned DOUBLE_ROUNDS = chacha_pkg::DoubleRoundsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [chacha_pkg::WordW-1:0]   req_block_counter,
   input  logic [chacha_pkg::WordW-1:0]   req_nonce_word_0,
   input  logic [chacha_pkg::WordW-1:0]   req_nonce_word_1,
   input  logic [chacha_pkg::WordW-1:0]   req_nonce_word_2,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [chacha_pkg::IdxW-1:0]    rsp_word_index,
   output logic [chacha_pkg::WordW-1:0]   rsp_keystream_word,
   output logic                           rsp_last_word,
   // configuration
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [chacha_pkg::AddrW-1:0]   paddr,
   input  logic [chacha_pkg::WordW-1:0]   pwdata,
   output logic [chacha_pkg::WordW-1:0]   prdata,
   output logic                           pready
);
   import chacha_pkg::*;

   localparam int unsigned DrW = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
   localparam logic [DrW-1:0] DrLast = DrW'(DOUBLE_ROUNDS - 1);

   logic [WordW-1:0] key_ff [KeyN];
   logic [WordW-1:0] in_ff  [4];
   logic [WordW-1:0] in_in  [4];
   logic [WordW-1:0] w_ff   [16];
   logic [WordW-1:0] w_in   [16];
   logic [PcW-1:0]   pc_ff, pc_in;
   logic [DrW-1:0]   dr_ff, dr_in;
   logic [IdxW-1:0]  emit_ff, emit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IdxW-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [WordW-1:0] rsp_word_ff, rsp_word_in;
   logic             rsp_last_ff, rsp_last_in;

   ucode_type        uc;
   logic             req_take;
   logic             emit_go;
   logic             out_free;
   logic [3:0]       ia [4];
   logic [3:0]       ib [4];
   logic [3:0]       ic [4];
   logic [3:0]       id [4];
   logic [WordW-1:0] sum [4];
   logic [WordW-1:0] init_w [16];

   assign uc = ucode_rom(pc_ff);

   // ---------------- configuration ----------------
   assign pready = 1'b1;
   assign prdata = key_ff[paddr[AddrW-1:2]];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KeyN; i++) key_ff[i] <= '0;
      end else if (psel && penable && pwrite) begin
         key_ff[paddr[AddrW-1:2]] <= pwdata;
      end
   end

   // ---------------- handshake ----------------
   assign req_stall = (uc.op != OP_LOAD);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_go   = (uc.op == OP_EMIT) && out_free;

   // ---------------- sequencer ----------------
   always_comb begin
      pc_in = pc_ff + 1'b1;
      dr_in = dr_ff;
      unique case (uc.cond)
         COND_NONE: pc_in = pc_ff + 1'b1;
         COND_REQ: begin
            pc_in = req_take ? pc_ff + 1'b1 : pc_ff;
            if (req_take) dr_in = '0;
         end
         COND_LOOP: begin
            if (dr_ff == DrLast) begin
               pc_in = pc_ff + 1'b1;
            end else begin
               pc_in = uc.target;
               dr_in = dr_ff + 1'b1;
            end
         end
         COND_EMIT: pc_in = (emit_go && emit_ff == 4'd15) ? uc.target : pc_ff;
         COND_JUMP: pc_in = uc.target;
         default:   pc_in = uc.target;
      endcase
   end

   // ---------------- datapath ----------------
   // initial state words for the final add
   always_comb begin
      for (int i = 0; i < 4; i++) init_w[i] = SIGMA[i];
      for (int i = 0; i < KeyN; i++) init_w[4 + i] = key_ff[i];
      for (int i = 0; i < 4; i++) init_w[12 + i] = in_ff[i];
   end

   // lane word indices: column or diagonal
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         ia[l] = {2'd0, 2'(l)};
         ib[l] = {2'd1, 2'(l + (uc.diag ? 1 : 0))};
         ic[l] = {2'd2, 2'(l + (uc.diag ? 2 : 0))};
         id[l] = {2'd3, 2'(l + (uc.diag ? 3 : 0))};
      end
   end

   always_comb begin
      w_in  = w_ff;
      in_in = in_ff;
      for (int l = 0; l < 4; l++) sum[l] = '0;
      case (uc.op)
         OP_LOAD: begin
            if (req_take) begin
               in_in[0] = req_block_counter;
               in_in[1] = req_nonce_word_0;
               in_in[2] = req_nonce_word_1;
               in_in[3] = req_nonce_word_2;
               for (int i = 0; i < 4; i++) w_in[i] = SIGMA[i];
               for (int i = 0; i < KeyN; i++) w_in[4 + i] = key_ff[i];
               w_in[12] = req_block_counter;
               w_in[13] = req_nonce_word_0;
               w_in[14] = req_nonce_word_1;
               w_in[15] = req_nonce_word_2;
            end
         end
         OP_ROUND: begin
            // even phases: a += b, d = rotl(d ^ a); odd: c += d, b = rotl(b ^ c)
            for (int l = 0; l < 4; l++) begin
               if (!uc.phase[0]) begin
                  sum[l] = w_ff[ia[l]] + w_ff[ib[l]];
                  w_in[ia[l]] = sum[l];
                  w_in[id[l]] = rotl(w_ff[id[l]] ^ sum[l], uc.phase);
               end else begin
                  sum[l] = w_ff[ic[l]] + w_ff[id[l]];
                  w_in[ic[l]] = sum[l];
                  w_in[ib[l]] = rotl(w_ff[ib[l]] ^ sum[l], uc.phase);
               end
            end
         end
         OP_FINAL: begin
            for (int i = 0; i < 16; i++) w_in[i] = w_ff[i] + init_w[i];
         end
         default: ;
      endcase
   end

   // ---------------- output register ----------------
   always_comb begin
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_idx_in   = rsp_idx_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      if (req_take) emit_in = '0;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = emit_ff;
         rsp_word_in  = w_ff[emit_ff];
         rsp_last_in  = (emit_ff == 4'd15);
         emit_in      = emit_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_LOAD;
         dr_ff        <= '0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         dr_ff        <= dr_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      in_ff       <= in_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_word_index     = rsp_idx_ff;
   assign rsp_keystream_word = rsp_word_ff;
   assign rsp_last_word      = rsp_last_ff;

   // ---------------- assertions ----------------
   `ASSERT_NEXT(a_take_starts_rounds, clock, reset, req_take, (pc_ff == PC_ROUND && dr_ff == '0))
   `ASSERT_IMPLY(a_pc_in_rom, clock, reset, 1'b1, (pc_ff <= PC_LAST))
   `ASSERT_IMPLY(a_load_emit_clear, clock, reset, !req_stall, (emit_ff == '0))
   `ASSERT_IMPLY(a_last_is_fifteen, clock, reset, rsp_valid_ff && rsp_last_ff,
                 (rsp_idx_ff == 4'd15))

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ChaCha20 keystream block generator.
// ----------------------------------------------------------------------------
// Key words are written over the APB port, and counter/nonce requests are
// streamed in under random source gaps and sink stalls. A behavioral
// ChaCha20 model in the bench computes the 16 words of every accepted
// request, and each returned word is compared field by field in order.
// The tests cover the reset key, the published RFC 7539 vector, extreme
// field values, key changes between blocks, a long sink hold-off that backs
// up the request side, and random traffic under several keys.
// ----------------------------------------------------------------------------
module tb;
   import chacha_pkg::*;

   localparam int unsigned KeyWord0Idx = 0;
   localparam int unsigned BlockWords  = 16;
   localparam int unsigned DrainCycles = 100;
   localparam int unsigned HoldCycles  = 400;

   typedef logic [WordW-1:0] word_type;
   typedef logic [BlockWords-1:0][WordW-1:0] block_words_type;

   typedef struct packed {
      logic [IdxW-1:0] word_index;
      word_type        keystream_word;
      logic            last_word;
   } keystream_word_type;

   logic clock;
   logic reset;

   logic                req_valid = 1'b0;
   logic                req_stall;
   word_type            req_block_counter = '0;
   word_type            req_nonce_word_0 = '0;
   word_type            req_nonce_word_1 = '0;
   word_type            req_nonce_word_2 = '0;

   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [IdxW-1:0]     rsp_word_index;
   word_type            rsp_keystream_word;
   logic                rsp_last_word;

   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [AddrW-1:0]    paddr = '0;
   word_type            pwdata = '0;
   word_type            prdata;
   logic                pready;

   word_type            key_shadow [KeyN];
   keystream_word_type  keystream_q [$];
   int unsigned         error_count = 0;
   bit                  req_quiet = 1'b0;
   bit                  rsp_quiet = 1'b0;
   int unsigned         rsp_hold = 0;

   chacha20_block_function dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_block_counter  (req_block_counter),
      .req_nonce_word_0   (req_nonce_word_0),
      .req_nonce_word_1   (req_nonce_word_1),
      .req_nonce_word_2   (req_nonce_word_2),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_word_index     (rsp_word_index),
      .rsp_keystream_word (rsp_keystream_word),
      .rsp_last_word      (rsp_last_word),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Keystream model
   // ---------------------------------------------------------------------
   function automatic word_type rol32(input word_type v, input int unsigned n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic block_words_type quarter_round(input block_words_type s,
         input int unsigned a, input int unsigned b,
         input int unsigned c, input int unsigned d);
      s[a] = s[a] + s[b]; s[d] = rol32(s[d] ^ s[a], 16);
      s[c] = s[c] + s[d]; s[b] = rol32(s[b] ^ s[c], 12);
      s[a] = s[a] + s[b]; s[d] = rol32(s[d] ^ s[a], 8);
      s[c] = s[c] + s[d]; s[b] = rol32(s[b] ^ s[c], 7);
      return s;
   endfunction

   // Queues the 16 keystream words for one counter/nonce under the current key.
   function automatic void predict_keystream(input word_type counter, input word_type n0,
                                             input word_type n1, input word_type n2);
      block_words_type    init_words;
      block_words_type    mix;
      keystream_word_type kw;
      for (int i = 0; i < 4; i++) init_words[i] = SIGMA[i];
      for (int i = 0; i < KeyN; i++) init_words[4 + i] = key_shadow[i];
      init_words[12] = counter;
      init_words[13] = n0;
      init_words[14] = n1;
      init_words[15] = n2;
      mix = init_words;
      for (int r = 0; r < DoubleRoundsDefault; r++) begin
         mix = quarter_round(mix, 0, 4, 8, 12);
         mix = quarter_round(mix, 1, 5, 9, 13);
         mix = quarter_round(mix, 2, 6, 10, 14);
         mix = quarter_round(mix, 3, 7, 11, 15);
         mix = quarter_round(mix, 0, 5, 10, 15);
         mix = quarter_round(mix, 1, 6, 11, 12);
         mix = quarter_round(mix, 2, 7, 8, 13);
         mix = quarter_round(mix, 3, 4, 9, 14);
      end
      for (int i = 0; i < BlockWords; i++) begin
         kw.word_index     = i[IdxW-1:0];
         kw.keystream_word = mix[i] + init_words[i];
         kw.last_word      = (i == BlockWords - 1);
         keystream_q.push_back(kw);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Result sink: stall generator and word checker
   // ---------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold != 0) begin
            rsp_stall <= 1'b1;
            rsp_hold = rsp_hold - 1;
         end else if (rsp_quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 15);
         end
      end
   end

   always @(posedge clock) begin : check_words
      keystream_word_type exp_word;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (keystream_q.size() == 0) begin
            $error("keystream word with nothing outstanding: index %0d word %h",
                   rsp_word_index, rsp_keystream_word);
            error_count++;
         end else begin
            exp_word = keystream_q.pop_front();
            if (rsp_word_index !== exp_word.word_index) begin
               $error("word_index: expected %0d, got %0d",
                      exp_word.word_index, rsp_word_index);
               error_count++;
            end
            if (rsp_keystream_word !== exp_word.keystream_word) begin
               $error("keystream_word: expected %h, got %h",
                      exp_word.keystream_word, rsp_keystream_word);
               error_count++;
            end
            if (rsp_last_word !== exp_word.last_word) begin
               $error("last_word: expected %0b, got %0b",
                      exp_word.last_word, rsp_last_word);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request driver and register access
   // ---------------------------------------------------------------------
   task automatic send_request(input word_type counter, input word_type n0,
                               input word_type n1, input word_type n2);
      while (!req_quiet && $urandom_range(99) < 15) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_block_counter <= counter;
      req_nonce_word_0  <= n0;
      req_nonce_word_1  <= n1;
      req_nonce_word_2  <= n2;
      do @(posedge clock); while (req_stall);
      predict_keystream(counter, n0, n1, n2);
   endtask

   task automatic send_random_request();
      send_request($urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic stop_requests();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Waits for every outstanding word, then lets the block settle.
   task automatic wait_drain();
      stop_requests();
      while (keystream_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_key_word(input int unsigned idx, input word_type value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= AddrW'(4 * idx);
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      key_shadow[idx - KeyWord0Idx] = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic check_key_word(input int unsigned idx);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= AddrW'(4 * idx);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== key_shadow[idx - KeyWord0Idx]) begin
         $error("key_word_%0d: expected %h, got %h",
                idx - KeyWord0Idx, key_shadow[idx - KeyWord0Idx], prdata);
         error_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic load_key(input word_type k [KeyN]);
      for (int i = 0; i < KeyN; i++) write_key_word(KeyWord0Idx + i, k[i]);
      for (int i = 0; i < KeyN; i++) check_key_word(KeyWord0Idx + i);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_reset_key();
      for (int i = 0; i < KeyN; i++) check_key_word(KeyWord0Idx + i);
      send_request('0, '0, '0, '0);
      send_request('1, '1, '1, '1);
      wait_drain();
   endtask

   // RFC 7539 section 2.3.2 block function vector.
   task automatic test_rfc_vector();
      word_type k [KeyN];
      for (int i = 0; i < KeyN; i++)
         k[i] = {8'(4 * i + 3), 8'(4 * i + 2), 8'(4 * i + 1), 8'(4 * i)};
      load_key(k);
      send_request(32'h0000_0001, 32'h0900_0000, 32'h4a00_0000, 32'h0000_0000);
      send_request(32'h0000_0002, 32'h0900_0000, 32'h4a00_0000, 32'h0000_0000);
      wait_drain();
   endtask

   task automatic test_field_extremes();
      word_type k [KeyN];
      for (int i = 0; i < KeyN; i++) k[i] = '1;
      load_key(k);
      send_request('0, '0, '0, '0);
      send_request('1, '1, '1, '1);
      send_request(32'hffff_ffff, '0, '0, '0);
      send_request('0, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
      send_request(32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001);
      wait_drain();
      for (int i = 0; i < KeyN; i++) k[i] = (i % 2) ? 32'h5555_5555 : 32'haaaa_aaaa;
      load_key(k);
      send_request(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
      send_request('0, '1, '0, '1);
      wait_drain();
   endtask

   // A single key word change must show up in the next block only.
   task automatic test_key_change();
      word_type counter, n0, n1, n2;
      counter = $urandom;
      n0 = $urandom;
      n1 = $urandom;
      n2 = $urandom;
      for (int i = 0; i < KeyN; i++) begin
         send_request(counter, n0, n1, n2);
         wait_drain();
         write_key_word(KeyWord0Idx + i, key_shadow[i] ^ (32'h1 << $urandom_range(31)));
      end
      send_request(counter, n0, n1, n2);
      wait_drain();
   endtask

   // Sink holds off long enough for the request side to back up.
   task automatic test_backpressure();
      rsp_hold = HoldCycles;
      for (int i = 0; i < 6; i++) send_random_request();
      wait_drain();
   endtask

   task automatic test_random_traffic();
      word_type k [KeyN];
      word_type counter, n0, n1, n2;
      for (int phase = 0; phase < 4; phase++) begin
         for (int i = 0; i < KeyN; i++) k[i] = $urandom;
         load_key(k);
         // the second phase runs with no idling on either side
         req_quiet = (phase == 1);
         rsp_quiet = (phase == 1);
         counter = $urandom;
         n0 = $urandom;
         n1 = $urandom;
         n2 = $urandom;
         for (int n = 0; n < 70; n++) begin
            case ($urandom_range(9))
               0, 1, 2, 3: begin
                  // stream of consecutive blocks under one nonce
                  counter = counter + 1;
                  send_request(counter, n0, n1, n2);
               end
               4: send_request($urandom_range(1) ? '1 : '0, $urandom, $urandom,
                               $urandom_range(1) ? '1 : '0);
               default: send_random_request();
            endcase
         end
         wait_drain();
      end
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < KeyN; i++) key_shadow[i] = '0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_key();
      test_rfc_vector();
      test_field_extremes();
      test_key_change();
      test_backpressure();
      test_random_traffic();

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
